// File: hw/rtl/polyline_length_accumulator_defines.svh
// assertion macros used by the checker file
`ifndef POLYLINE_LENGTH_ACCUMULATOR_DEFINES_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PLA_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("pla assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PLA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("pla assertion failed");

`endif

// File: hw/rtl/pla_pkg.sv
package pla_pkg;

    // coordinate and sum widths
    localparam int COORD_BITS = 24;
    localparam int SUM_BITS   = 48;
    localparam int TOTAL_BITS = 48;

    // square root sizing: radicand is dx^2 + dy^2, padded to an even width
    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int CNT_BITS  = $clog2(ROOT_BITS);

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic acc;
        logic emit;
    } pla_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic have_vertex;
        logic last;
        logic out_free;
    } pla_status_t;

endpackage

// File: hw/rtl/pla_ctrl.sv
module pla_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_vertex,
    output logic                 in_stall,
    input  pla_pkg::pla_status_t status,
    output pla_pkg::pla_cmd_t    cmd
);
    import pla_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQX  = 3'd1;
    localparam logic [2:0] S_SQY  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (status.have_vertex)
                        state_next = S_SQX;
                    else if (last_vertex)
                        state_next = S_EMIT;
                end
            end
            S_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.sq_y   = 1'b1;
                cnt_next   = CNT_BITS'(ROOT_BITS - 1);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_ACC;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/pla_datapath.sv
module pla_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [pla_pkg::COORD_BITS-1:0] x_coord,
    input  logic signed [pla_pkg::COORD_BITS-1:0] y_coord,
    input  logic                                  last_vertex,
    input  pla_pkg::pla_cmd_t                     cmd,
    output pla_pkg::pla_status_t                  status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [pla_pkg::TOTAL_BITS-1:0]        total_length,
    output logic                                  saturated
);
    import pla_pkg::*;

    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                  have_reg;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic                  clamp_reg, clamp_next;
    logic [COORD_BITS-1:0] mag_x_reg, mag_y_reg;
    logic                  last_reg;
    logic [RAD_BITS-1:0]   rad_reg;
    logic [REM_BITS-1:0]   rem_reg;
    logic [ROOT_BITS-1:0]  root_reg;
    logic                  out_valid_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic                  sat_reg;

    logic [COORD_BITS:0]   dx, dy, neg_dx, neg_dy;
    logic [COORD_BITS-1:0] mag_x, mag_y, mul_a;
    logic [PROD_BITS-1:0]  prod;
    logic [REM_BITS-1:0]   rem_shift;
    logic [REM_BITS:0]     trial;
    logic                  root_bit;
    logic [SUM_BITS:0]     sum_ext;
    logic [63:0]           sum_wide;
    logic                  out_free;

    // segment deltas against the held vertex
    assign dx     = {x_coord[COORD_BITS-1], x_coord} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
    assign dy     = {y_coord[COORD_BITS-1], y_coord} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
    assign neg_dx = ~dx + 1'b1;
    assign neg_dy = ~dy + 1'b1;
    assign mag_x  = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign mag_y  = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    // one shared squarer
    assign mul_a = cmd.sq_y ? mag_y_reg : mag_x_reg;
    assign prod  = PROD_BITS'(mul_a) * PROD_BITS'(mul_a);

    // restoring square root, two radicand bits per step
    assign rem_shift = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial     = {1'b0, rem_shift} - {1'b0, root_reg, 2'b01};
    assign root_bit  = !trial[REM_BITS];

    // saturating accumulate, carry out means clamp
    assign sum_ext = {1'b0, sum_reg} + (SUM_BITS + 1)'(root_reg);
    always_comb
    begin
        if (sum_ext[SUM_BITS])
        begin
            sum_next   = '1;
            clamp_next = 1'b1;
        end
        else
        begin
            sum_next   = sum_ext[SUM_BITS-1:0];
            clamp_next = clamp_reg;
        end
    end

    assign sum_wide = 64'(sum_reg);
    assign out_free = !out_valid_reg || !out_stall;

    assign status.have_vertex = have_reg;
    assign status.last        = last_reg;
    assign status.out_free    = out_free;

    assign out_valid    = out_valid_reg;
    assign total_length = total_reg;
    assign saturated    = sat_reg;

    // polyline state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            have_reg   <= 1'b0;
            sum_reg    <= '0;
            clamp_reg  <= 1'b0;
        end
        else if (cmd.emit)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            have_reg   <= 1'b0;
            sum_reg    <= '0;
            clamp_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            prev_x_reg <= x_coord;
            prev_y_reg <= y_coord;
            have_reg   <= 1'b1;
        end
        else if (cmd.acc)
        begin
            sum_reg   <= sum_next;
            clamp_reg <= clamp_next;
        end
    end

    // segment working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_x_reg <= mag_x;
            mag_y_reg <= mag_y;
            last_reg  <= last_vertex;
        end
        if (cmd.sq_x)
        begin
            rad_reg  <= RAD_BITS'(prod);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sq_y)
        begin
            rad_reg <= rad_reg + RAD_BITS'(prod);
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_reg  <= root_bit ? trial[REM_BITS-1:0] : rem_shift;
            root_reg <= {root_reg[ROOT_BITS-2:0], root_bit};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            total_reg <= sum_wide[TOTAL_BITS-1:0];
            sat_reg   <= clamp_reg;
        end
    end

endmodule

// File: hw/rtl/polyline_length_accumulator.sv
// channel   dir  handshake            payload
// in        in   in_valid / in_stall  x_coord, y_coord, last_vertex
// out       out  out_valid / out_stall total_length, saturated
//
// one vertex a transaction; the first vertex of a polyline is only loaded and held
// every later vertex runs accept, two squarings on the shared multiplier,
// 25 steps of the restoring square root and one accumulate
// a vertex marked last then loads the result register once the output is free
// rst_n is asynchronous; it clears the held vertex, the sum and the result valid
// out_stall holds the result; a new polyline is taken meanwhile and only waits at its end
module polyline_length_accumulator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [pla_pkg::COORD_BITS-1:0] x_coord,
    input  logic signed [pla_pkg::COORD_BITS-1:0] y_coord,
    input  logic                                  last_vertex,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [pla_pkg::TOTAL_BITS-1:0]        total_length,
    output logic                                  saturated
);
    import pla_pkg::*;

    // command and status between sequencer and datapath
    pla_cmd_t    cmd;
    pla_status_t status;

    // sequencer: accept, square, root iterations, accumulate, emit
    pla_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_vertex (last_vertex),
        .in_stall    (in_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // held vertex, squarer, root unit, saturating sum and result register
    pla_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .last_vertex  (last_vertex),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .total_length (total_length),
        .saturated    (saturated)
    );

endmodule

// File: hw/rtl/polyline_length_accumulator_checker.sv
`include "polyline_length_accumulator_defines.svh"

module polyline_length_accumulator_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic signed [pla_pkg::COORD_BITS-1:0] x_coord,
    input logic signed [pla_pkg::COORD_BITS-1:0] y_coord,
    input logic                                  last_vertex,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [pla_pkg::TOTAL_BITS-1:0]        total_length,
    input logic                                  saturated
);
    import pla_pkg::*;

    localparam logic [64:0] SUM_MAX_W = (65'd1 << SUM_BITS) - 65'd1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = SUM_MAX_W[TOTAL_BITS-1:0];

    // a stalled result stays valid
    `PLA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // a stalled result keeps its payload
    `PLA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(total_length) && $stable(saturated))
    // a clamped sum shows the maximum
    `PLA_ASSERT_IMPLY(a_sat_max, clk, rst_n, out_valid && saturated, total_length == TOTAL_MAX)
    // the last vertex always keeps the block busy the next cycle
    `PLA_ASSERT_NEXT(a_last_busy, clk, rst_n, in_valid && !in_stall && last_vertex, in_stall)

endmodule

bind polyline_length_accumulator polyline_length_accumulator_checker u_checker (.*);
